// ===== rtl/lgtb_pkg.sv =====
// ----------------------------------------------------------------------------
// lgtb_pkg
// Shared constants and helpers for the tensor-product Legendre basis core.
// ----------------------------------------------------------------------------
package lgtb_pkg;

  localparam int unsigned MAX_ORDER_DEF = 7;
  localparam int unsigned FRAC_BITS     = 14;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned IDX_W         = 3;
  // Shared multiplier operand width; the product is twice as wide.
  localparam int unsigned MUL_W         = 24;
  // Recurrence numerator width, and the width of the rounded quotient input.
  localparam int unsigned NUM_W         = 38;
  localparam int unsigned A_W           = NUM_W - FRAC_BITS;
  // Reciprocal scale used for the division by k+1.
  localparam int unsigned RCP_SHIFT     = 23;

  localparam logic signed [COORD_W-1:0] P0_VALUE = COORD_W'(1 << FRAC_BITS);
  localparam logic [A_W-1:0] SAT_POS_MAG = A_W'((1 << (COORD_W - 1)) - 1);
  localparam logic [A_W-1:0] SAT_NEG_MAG = A_W'(1 << (COORD_W - 1));

  // floor(2^RCP_SHIFT / d) for the divisors that the recurrence needs.
  function automatic logic [MUL_W-1:0] recip(input logic [IDX_W-1:0] d);
    logic [MUL_W-1:0] r;
    case (d)
      3'd2:    r = MUL_W'(4194304);
      3'd3:    r = MUL_W'(2796202);
      3'd4:    r = MUL_W'(2097152);
      3'd5:    r = MUL_W'(1677721);
      3'd6:    r = MUL_W'(1398101);
      3'd7:    r = MUL_W'(1198372);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Applies a sign to a magnitude and saturates to the 16-bit signed range.
  function automatic logic signed [COORD_W-1:0] sat_mag(input logic [A_W-1:0] mag,
                                                       input logic neg);
    logic signed [COORD_W-1:0] r;
    if (neg) begin
      r = (mag > SAT_NEG_MAG) ? {1'b1, {(COORD_W-1){1'b0}}}
                              : -$signed(mag[COORD_W-1:0]);
    end else begin
      r = (mag > SAT_POS_MAG) ? {1'b0, {(COORD_W-1){1'b1}}}
                              : $signed(mag[COORD_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/lgtb_mul.sv =====
// ----------------------------------------------------------------------------
// lgtb_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lgtb_mul import lgtb_pkg::*; #(
  parameter int unsigned W = MUL_W
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/lgtb_store.sv =====
// ----------------------------------------------------------------------------
// lgtb_store
// Small coefficient memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lgtb_store import lgtb_pkg::*; #(
  parameter int unsigned DEPTH  = MAX_ORDER_DEF + 1,
  parameter int unsigned ADDR_W = 3
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic signed [COORD_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic signed [COORD_W-1:0] rdata_o
);

  logic signed [COORD_W-1:0] mem [DEPTH];
  logic signed [COORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/legendre_tensor_basis_eval_core.sv =====
// ----------------------------------------------------------------------------
// legendre_tensor_basis_eval_core
// Evaluates P0..Pn at u and v and streams the (n+1)^2 tensor products.
// ----------------------------------------------------------------------------
// After the input beat the core runs the recurrence for u, then for v, then
// reads, multiplies and emits each product in turn, stalling while the sink
// is not ready; a new point is taken only after the last product is emitted.
// One shared multiplier does every recurrence and product multiply in turn.
// Reset (rst_ni low, asynchronous) clears control and sets the order to 1;
// the coefficient stores are not cleared.
module legendre_tensor_basis_eval_core import lgtb_pkg::*; #(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,    // poly_order
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // u_coord[15:0], v_coord[31:16]
  input  logic [1:0]  s_axis_tuser,   // flip_first[0], flip_second[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // basis_value[15:0], first_index[18:16], second_index[21:19],
  // term_degree[24:22], zero[31:25]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned DEPTH  = MAX_ORDER + 1;
  localparam int unsigned ADDR_W = (MAX_ORDER > 0) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_MUL_C, S_MUL_T1, S_MUL_T2, S_NUM, S_ABS,
    S_MUL_RCP, S_MUL_CHK, S_STEP, S_P_RD, S_P_MUL, S_P_EMIT
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    poly_order_q;
  logic                m_valid_q;

  logic signed [COORD_W-1:0] x_u_q, x_v_q, pk_q, pkm1_q;
  logic                      fu_q, fv_q, cs_q, neg_q;
  logic [IDX_W-1:0]          n_q, k_q, i_q, j_q;
  logic signed [NUM_W-1:0]   t1_q, num_q;
  logic [A_W-1:0]            a_q, q0_q;

  logic signed [COORD_W-1:0] m_val_q;
  logic [IDX_W-1:0]          m_i_q, m_j_q, m_deg_q;
  logic                      m_last_q;

  logic                      accept, out_free, emit_fire, last_term;
  logic [IDX_W-1:0]          d, n_clamp;
  logic signed [COORD_W-1:0] x_sel, step_val, prod_val, rd_u, rd_v;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [NUM_W-1:0]          num_mag, num_sum;
  logic [A_W-1:0]            rem, q_fix;
  logic [2*MUL_W-1:0]        prod_mag, prod_sum;
  logic                      prod_neg;
  logic                      we_u, we_v;
  logic [ADDR_W-1:0]         waddr;
  logic signed [COORD_W-1:0] wdata_u, wdata_v;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign emit_fire = (state_q == S_P_EMIT) && out_free;
  assign last_term = (i_q == n_q) && (j_q == n_q);
  assign d         = k_q + IDX_W'(1);
  assign x_sel     = cs_q ? x_v_q : x_u_q;
  assign n_clamp   = (poly_order_q > IDX_W'(MAX_ORDER)) ? IDX_W'(MAX_ORDER) : poly_order_q;

  // Round-to-nearest of |num| / ((k+1) * 2^F): the 2^F part is a shift.
  assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign num_sum = num_mag + (NUM_W'(d) << (FRAC_BITS - 1));

  // The reciprocal estimate is exact or one short; one compare corrects it.
  assign rem      = a_q - mul_p[A_W-1:0];
  assign q_fix    = q0_q + A_W'(rem >= A_W'(d));
  assign step_val = sat_mag(q_fix, neg_q);

  assign prod_mag = mul_p[2*MUL_W-1] ? (2*MUL_W)'(-mul_p) : (2*MUL_W)'(mul_p);
  assign prod_sum = prod_mag + (2*MUL_W)'(1 << (FRAC_BITS - 1));
  assign prod_neg = mul_p[2*MUL_W-1] ^ (fu_q & ~i_q[0]) ^ (fv_q & ~j_q[0]);
  assign prod_val = sat_mag(prod_sum[FRAC_BITS +: A_W], prod_neg);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_MUL_C: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_W'({k_q, 1'b1}));
        mul_b  = MUL_W'(x_sel);
      end
      S_MUL_T1: begin
        mul_en = 1'b1;
        mul_a  = mul_p[MUL_W-1:0];
        mul_b  = MUL_W'(pk_q);
      end
      S_MUL_T2: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_W'(k_q));
        mul_b  = MUL_W'(pkm1_q);
      end
      S_MUL_RCP: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_W'(a_q));
        mul_b  = $signed(recip(d));
      end
      S_MUL_CHK: begin
        mul_en = 1'b1;
        mul_a  = $signed(mul_p[RCP_SHIFT +: MUL_W]);
        mul_b  = $signed(MUL_W'(d));
      end
      S_P_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(rd_u);
        mul_b  = MUL_W'(rd_v);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // P0 is written on the input beat, P1 in the next cycle, then P2..Pn.
  always_comb begin
    we_u    = 1'b0;
    we_v    = 1'b0;
    waddr   = ADDR_W'(d);
    wdata_u = step_val;
    wdata_v = step_val;
    case (state_q)
      S_IDLE: begin
        we_u    = accept;
        we_v    = accept;
        waddr   = '0;
        wdata_u = P0_VALUE;
        wdata_v = P0_VALUE;
      end
      S_P1: begin
        we_u    = (n_q != '0);
        we_v    = (n_q != '0);
        waddr   = ADDR_W'(1);
        wdata_u = x_u_q;
        wdata_v = x_v_q;
      end
      S_STEP: begin
        we_u = !cs_q;
        we_v = cs_q;
      end
      default: begin
        we_u = 1'b0;
      end
    endcase
  end

  lgtb_mul #(.W(MUL_W)) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  lgtb_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store_u (
    .clk_i   (clk_i),
    .we_i    (we_u),
    .waddr_i (waddr),
    .wdata_i (wdata_u),
    .raddr_i (i_q[ADDR_W-1:0]),
    .rdata_o (rd_u)
  );

  lgtb_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store_v (
    .clk_i   (clk_i),
    .we_i    (we_v),
    .waddr_i (waddr),
    .wdata_i (wdata_v),
    .raddr_i (j_q[ADDR_W-1:0]),
    .rdata_o (rd_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      m_valid_q    <= 1'b0;
      poly_order_q <= IDX_W'(1);
    end else begin
      if (cfg_we_i) begin
        poly_order_q <= cfg_wdata_i;
      end
      if (emit_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:    if (accept) state_q <= S_P1;
        S_P1:      state_q <= (n_q >= IDX_W'(2)) ? S_MUL_C : S_P_RD;
        S_MUL_C:   state_q <= S_MUL_T1;
        S_MUL_T1:  state_q <= S_MUL_T2;
        S_MUL_T2:  state_q <= S_NUM;
        S_NUM:     state_q <= S_ABS;
        S_ABS:     state_q <= S_MUL_RCP;
        S_MUL_RCP: state_q <= S_MUL_CHK;
        S_MUL_CHK: state_q <= S_STEP;
        S_STEP:    state_q <= ((d == n_q) && cs_q) ? S_P_RD : S_MUL_C;
        S_P_RD:    state_q <= S_P_MUL;
        S_P_MUL:   state_q <= S_P_EMIT;
        S_P_EMIT: begin
          if (out_free) state_q <= last_term ? S_IDLE : S_P_RD;
        end
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          x_u_q <= $signed(s_axis_tdata[15:0]);
          x_v_q <= $signed(s_axis_tdata[31:16]);
          fu_q  <= s_axis_tuser[0];
          fv_q  <= s_axis_tuser[1];
          n_q   <= n_clamp;
        end
      end
      S_P1: begin
        cs_q   <= 1'b0;
        k_q    <= IDX_W'(1);
        pkm1_q <= P0_VALUE;
        pk_q   <= x_u_q;
        i_q    <= '0;
        j_q    <= '0;
      end
      S_MUL_T2: t1_q  <= $signed(mul_p[NUM_W-1:0]);
      S_NUM:    num_q <= t1_q - ($signed(mul_p[NUM_W-1:0]) <<< FRAC_BITS);
      S_ABS: begin
        a_q   <= num_sum[FRAC_BITS +: A_W];
        neg_q <= num_q[NUM_W-1];
      end
      S_MUL_CHK: q0_q <= mul_p[RCP_SHIFT +: A_W];
      S_STEP: begin
        if ((d == n_q) && !cs_q) begin
          // The u run is done; start the v run from P0 and P1.
          cs_q   <= 1'b1;
          k_q    <= IDX_W'(1);
          pkm1_q <= P0_VALUE;
          pk_q   <= x_v_q;
        end else begin
          pkm1_q <= pk_q;
          pk_q   <= step_val;
          k_q    <= d;
        end
        if (d == n_q) begin
          i_q <= '0;
          j_q <= '0;
        end
      end
      S_P_EMIT: begin
        if (out_free) begin
          m_val_q  <= prod_val;
          m_i_q    <= i_q;
          m_j_q    <= j_q;
          m_deg_q  <= (i_q > j_q) ? i_q : j_q;
          m_last_q <= last_term;
          if (j_q == n_q) begin
            j_q <= '0;
            i_q <= i_q + IDX_W'(1);
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
      end
      default: begin
        cs_q <= cs_q;
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_deg_q, m_j_q, m_i_q, m_val_q};
  assign m_axis_tlast  = m_last_q;

  a_degree_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24:22] == m_axis_tdata[18:16] ||
                       m_axis_tdata[24:22] == m_axis_tdata[21:19]) &&
                      m_axis_tdata[24:22] >= m_axis_tdata[18:16] &&
                      m_axis_tdata[24:22] >= m_axis_tdata[21:19])
    else $error("term degree is not the larger index");

  a_last_on_diagonal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[18:16] == m_axis_tdata[21:19]))
    else $error("last beat is not the highest term");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input taken again straight after a beat");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P_EMIT) |-> (i_q <= n_q && j_q <= n_q))
    else $error("product index beyond the order");

endmodule

// ===== bench/legendre_tensor_basis_eval_core_test.sv =====
// ----------------------------------------------------------------------------
// Tensor-product Legendre basis core testbench
// Streams points into the core across several basis orders. A scoreboard
// rebuilds the Legendre recurrence in fixed point, predicts every product beat
// and compares each output beat field by field. Both stream sides idle at
// random, and the sink holds off for one long stretch to back the core up.
// ----------------------------------------------------------------------------
module legendre_tensor_basis_eval_core_test;
  import lgtb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned PHASE_ITEMS = 24;

  typedef struct {
    logic signed [COORD_W-1:0] value;
    logic [IDX_W-1:0]          first_idx;
    logic [IDX_W-1:0]          second_idx;
    logic [IDX_W-1:0]          degree;
    logic                      last;
  } basis_term_t;

  class basis_scoreboard;
    int unsigned order_sel;
    int unsigned fail_count;
    longint      recur[8];
    longint      legendre_u[8];
    longint      legendre_v[8];
    basis_term_t pending_terms[$];

    function new();
      order_sel  = 1;
      fail_count = 0;
    endfunction

    function void set_order(int unsigned value);
      order_sel = value;
    endfunction

    function int unsigned pending_count();
      return pending_terms.size();
    endfunction

    // Nearest, ties away from zero; den is always positive.
    function longint round_near(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void fill_recurrence(longint x, int unsigned n);
      longint one;
      longint num;
      one = longint'(1) << FRAC_BITS;
      recur[0] = clip16(one);
      if (n >= 1) recur[1] = clip16(x);
      for (int k = 1; k < n; k++) begin
        num = longint'(2 * k + 1) * x * recur[k] - longint'(k) * recur[k-1] * one;
        recur[k+1] = clip16(round_near(num, longint'(k + 1) * one));
      end
    endfunction

    function void note_point(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v,
                             logic flip_a, logic flip_b);
      int unsigned n;
      longint      prod;
      bit          neg;
      basis_term_t t;
      n = (order_sel > MAX_ORDER_DEF) ? MAX_ORDER_DEF : order_sel;
      fill_recurrence(longint'(u), n);
      legendre_u = recur;
      fill_recurrence(longint'(v), n);
      legendre_v = recur;
      for (int i = 0; i <= n; i++) begin
        for (int j = 0; j <= n; j++) begin
          prod = round_near(legendre_u[i] * legendre_v[j], longint'(1) << FRAC_BITS);
          neg  = (flip_a && (i % 2 == 0)) ^ (flip_b && (j % 2 == 0));
          if (neg) prod = -prod;
          t.value      = COORD_W'(clip16(prod));
          t.first_idx  = IDX_W'(i);
          t.second_idx = IDX_W'(j);
          t.degree     = IDX_W'((i > j) ? i : j);
          t.last       = (i == n) && (j == n);
          pending_terms.push_back(t);
        end
      end
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    endfunction

    function void check_term(logic [31:0] data, logic last);
      basis_term_t want;
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual data %h last %b",
                 $time, data, last);
        fail_count++;
        return;
      end
      want = pending_terms.pop_front();
      if ($signed(data[15:0]) !== want.value)
        report("basis_value", want.value, $signed(data[15:0]));
      if (data[18:16] !== want.first_idx) report("first_index", want.first_idx, data[18:16]);
      if (data[21:19] !== want.second_idx) report("second_index", want.second_idx, data[21:19]);
      if (data[24:22] !== want.degree) report("term_degree", want.degree, data[24:22]);
      if (data[31:25] !== 7'd0) report("tdata padding", 0, data[31:25]);
      if (last !== want.last) report("last_term", want.last, last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  basis_scoreboard sb;
  bit              hold_req = 1'b0;
  int unsigned     burst_left = 1;
  int unsigned     cycle_count = 0;

  legendre_tensor_basis_eval_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Both beats are sampled at the edge, so the values seen are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_point($signed(s_axis_tdata[15:0]), $signed(s_axis_tdata[31:16]),
                      s_axis_tuser[0], s_axis_tuser[1]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_term(m_axis_tdata, m_axis_tlast);
    end
  end

  // Sink: segments of differing stall patterns, plus one long hold-off on request.
  initial begin
    int unsigned seg;
    int unsigned mode;
    int unsigned tick;
    tick = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 150);
      repeat (seg) begin
        @(posedge clk_i);
        tick++;
        if (hold_req) begin
          hold_req = 1'b0;
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (tick % 5 != 0);
          endcase
        end
      end
    end
  end

  task automatic send_point(input logic signed [15:0] u, input logic signed [15:0] v,
                            input logic flip_a, input logic flip_b);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, u};
    s_axis_tuser  <= {flip_b, flip_a};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (burst_left == 0) begin
      // Gaps are never empty, so tvalid never drops and rises in one step.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 6);
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The source goes idle first so the last point is not offered a second time.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_order(input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[2:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_order(value);
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return -16'sd16384;
          1:       return 16'sd16384;
          2:       return 16'sd0;
          3:       return -16'sd32768;
          default: return 16'sd32767;
        endcase
      end
      1:       return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin
    int unsigned phase_order[11];
    phase_order = '{3, 7, 2, 5, 1, 4, 6, 0, 7, 3, 2};
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset order of one: the ends of the unit interval and a point beyond it.
    send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_point(16'sd16384, -16'sd16384, 1'b1, 1'b0);
    send_point(-16'sd16384, 16'sd16384, 1'b0, 1'b1);
    send_point(-16'sd32768, 16'sd32767, 1'b1, 1'b1);
    wait_for_results();

    // Highest order, where coordinates outside the interval make the recurrence saturate.
    write_order(7);
    send_point(16'sd16384, 16'sd16384, 1'b0, 1'b0);
    send_point(-16'sd16384, -16'sd16384, 1'b1, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1, 1'b0);
    send_point(16'sd8192, -16'sd8192, 1'b0, 1'b1);
    send_point(-16'sd16383, 16'sd16383, 1'b1, 1'b1);
    send_point(16'sd1, -16'sd1, 1'b0, 1'b0);
    send_point(16'sd24000, -16'sd24000, 1'b1, 1'b0);
    wait_for_results();

    // Order zero: a single constant term per point.
    write_order(0);
    send_point(16'sd16384, -16'sd32768, 1'b1, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
    wait_for_results();

    foreach (phase_order[p]) begin
      write_order(phase_order[p]);
      if (p == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS)
        send_point(pick_coord(), pick_coord(), $urandom_range(0, 1), $urandom_range(0, 1));
      wait_for_results();
    end

    s_axis_tvalid <= 1'b0;
    wait_for_results();
    if (sb.fail_count == 0 && sb.pending_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lgtb_pkg.sv
rtl/lgtb_mul.sv
rtl/lgtb_store.sv
rtl/legendre_tensor_basis_eval_core.sv
bench/legendre_tensor_basis_eval_core_test.sv
